@@ design/indexed_table_with_search_assert.svh @@
// Assertion macros for the checker of the indexed table.
`ifndef INDEXED_TABLE_WITH_SEARCH_ASSERT_SVH
`define INDEXED_TABLE_WITH_SEARCH_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ITWS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ITWS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ design/itws_pkg.sv @@
`timescale 1ns / 1ps

package itws_pkg;

   localparam int DEPTH_DEFAULT = 1024;
   localparam int DATA_W        = 32;
   localparam int INDEX_W       = 10;
   localparam int COUNT_W       = 11;

   typedef enum logic [1:0] {
      MODE_APPEND = 2'd0,
      MODE_READ   = 2'd1,
      MODE_WRITE  = 2'd2,
      MODE_SEARCH = 2'd3
   } itws_mode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_SEARCH
   } itws_state_type;

   typedef struct packed {
      itws_mode_type             mode;
      logic signed [DATA_W-1:0]  value;
      logic [INDEX_W-1:0]        index;
   } itws_req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0]  read_data;
      logic [INDEX_W-1:0]        position;
      logic                      found;
      logic                      error;
      logic [COUNT_W-1:0]        fill_count;
      logic                      is_empty;
   } itws_rsp_type;

endpackage

@@ design/indexed_table_with_search.sv @@
`timescale 1ns / 1ps

// Bounded table of signed 32-bit words with a fill count, held in one
// memory of DEPTH entries with a single registered read port. A request word
// is taken when start is high and busy is low; every request yields exactly
// one result word, marked by rsp_valid for a single cycle, which the receiver
// must take as it comes. Append and write, and any request answered by an
// error or by a search of an empty table, are answered from the idle state:
// the result shows in the next cycle and busy stays low, so such requests may
// follow every cycle. A read holds busy high in the read state while the
// memory returns the word, so no new request is taken until it is done. A
// search walks the entries one memory read per cycle, from entry 0 up to the
// first match or, when nothing matches, through the last filled entry; busy
// stays high until the result is issued. The memory needs no clearing after
// reset, since only written entries are ever read.
module indexed_table_with_search #(
   parameter int DEPTH = itws_pkg::DEPTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  itws_pkg::itws_req_type req_word,
   output logic                   rsp_valid,
   output itws_pkg::itws_rsp_type rsp_word
);
   import itws_pkg::*;

   localparam int AW = $clog2(DEPTH);

   logic              mem_wr_en;
   logic [AW-1:0]     mem_wr_addr;
   logic [DATA_W-1:0] mem_wr_data;
   logic              mem_rd_en;
   logic [AW-1:0]     mem_rd_addr;
   logic [DATA_W-1:0] mem_rd_data;

   itws_ctrl #(
      .DEPTH (DEPTH)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_word    (req_word),
      .rsp_valid   (rsp_valid),
      .rsp_word    (rsp_word),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

   itws_mem #(
      .DEPTH (DEPTH)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

endmodule

@@ design/itws_mem.sv @@
`timescale 1ns / 1ps

module itws_mem #(
   parameter int  DEPTH = itws_pkg::DEPTH_DEFAULT,
   localparam int AW    = $clog2(DEPTH)
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [AW-1:0]               wr_addr,
   input  logic [itws_pkg::DATA_W-1:0] wr_data,
   input  logic                        rd_en,
   input  logic [AW-1:0]               rd_addr,
   output logic [itws_pkg::DATA_W-1:0] rd_data
);
   import itws_pkg::*;

   logic [DATA_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

@@ design/itws_ctrl.sv @@
`timescale 1ns / 1ps

module itws_ctrl #(
   parameter int  DEPTH = itws_pkg::DEPTH_DEFAULT,
   localparam int AW    = $clog2(DEPTH)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  itws_pkg::itws_req_type      req_word,
   output logic                        rsp_valid,
   output itws_pkg::itws_rsp_type      rsp_word,
   output logic                        mem_wr_en,
   output logic [AW-1:0]               mem_wr_addr,
   output logic [itws_pkg::DATA_W-1:0] mem_wr_data,
   output logic                        mem_rd_en,
   output logic [AW-1:0]               mem_rd_addr,
   input  logic [itws_pkg::DATA_W-1:0] mem_rd_data
);
   import itws_pkg::*;

   localparam int CW = $clog2(DEPTH + 1);
   localparam int XW = (CW > INDEX_W) ? CW : INDEX_W;

   itws_state_type    state_ff, state_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [AW-1:0]     ptr_ff, ptr_in;
   logic [DATA_W-1:0] val_ff, val_in;
   itws_rsp_type      rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic [XW-1:0]     idx_x;
   logic [XW-1:0]     cnt_x;
   logic              in_range;
   logic              ptr_last;

   assign idx_x    = XW'(req_word.index);
   assign cnt_x    = XW'(count_ff);
   assign in_range = (idx_x < cnt_x);
   // The search pointer names the entry whose word is on the read port.
   assign ptr_last = ((CW'(ptr_ff) + CW'(1)) == count_ff);

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff <= ptr_in;
      val_ff <= val_in;
      rsp_ff <= rsp_in;
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      ptr_in       = ptr_ff;
      val_in       = val_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = 1'b0;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = count_ff[AW-1:0];
      mem_wr_data  = req_word.value;
      mem_rd_en    = 1'b0;
      mem_rd_addr  = idx_x[AW-1:0];

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               rsp_valid_in      = 1'b1;
               rsp_in            = '0;
               rsp_in.fill_count = COUNT_W'(count_ff);
               rsp_in.is_empty   = (count_ff == '0);
               case (req_word.mode)
                  MODE_APPEND: begin
                     if (count_ff < CW'(DEPTH)) begin
                        mem_wr_en         = 1'b1;
                        count_in          = count_ff + CW'(1);
                        rsp_in.fill_count = COUNT_W'(count_in);
                        rsp_in.is_empty   = 1'b0;
                     end else begin
                        rsp_in.error = 1'b1;
                     end
                  end
                  MODE_READ: begin
                     if (in_range) begin
                        // The memory registers the word; hold off new requests.
                        mem_rd_en    = 1'b1;
                        rsp_valid_in = 1'b0;
                        state_in     = ST_READ;
                     end else begin
                        rsp_in.error = 1'b1;
                     end
                  end
                  MODE_WRITE: begin
                     if (in_range) begin
                        mem_wr_en   = 1'b1;
                        mem_wr_addr = idx_x[AW-1:0];
                     end else begin
                        rsp_in.error = 1'b1;
                     end
                  end
                  MODE_SEARCH: begin
                     if (count_ff != '0) begin
                        mem_rd_en    = 1'b1;
                        mem_rd_addr  = '0;
                        ptr_in       = '0;
                        val_in       = req_word.value;
                        rsp_valid_in = 1'b0;
                        state_in     = ST_SEARCH;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_READ: begin
            rsp_valid_in      = 1'b1;
            rsp_in            = '0;
            rsp_in.read_data  = $signed(mem_rd_data);
            rsp_in.fill_count = COUNT_W'(count_ff);
            rsp_in.is_empty   = (count_ff == '0);
            state_in          = ST_IDLE;
         end
         ST_SEARCH: begin
            rsp_in            = '0;
            rsp_in.fill_count = COUNT_W'(count_ff);
            rsp_in.is_empty   = (count_ff == '0);
            if (mem_rd_data == val_ff) begin
               rsp_valid_in    = 1'b1;
               rsp_in.found    = 1'b1;
               rsp_in.position = INDEX_W'(ptr_ff);
               state_in        = ST_IDLE;
            end else if (ptr_last) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = ptr_ff + AW'(1);
               ptr_in      = mem_rd_addr;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

@@ design/itws_chk.sv @@
`timescale 1ns / 1ps

`include "indexed_table_with_search_assert.svh"

module itws_chk (
   input logic                   clock,
   input logic                   reset,
   input logic                   start,
   input logic                   busy,
   input itws_pkg::itws_req_type req_word,
   input logic                   rsp_valid,
   input itws_pkg::itws_rsp_type rsp_word
);
   import itws_pkg::*;

   // Appends and writes never stall: their word comes out the next cycle.
   `ITWS_ASSERT_NEXT(a_quick_modes, clock, reset, start && !busy && (req_word.mode == MODE_APPEND || req_word.mode == MODE_WRITE), rsp_valid, "append or write not answered in the next cycle")

   // Leaving a read or a search always issues its result word.
   `ITWS_ASSERT_NOW(a_busy_ends_with_rsp, clock, reset, !$past(reset) && $fell(busy), rsp_valid, "busy dropped without a result word")

   `ITWS_ASSERT_NOW(a_no_rsp_while_busy, clock, reset, rsp_valid, !busy, "result word issued while still busy")

   `ITWS_ASSERT_NOW(a_found_consistent, clock, reset, rsp_valid && rsp_word.found, !rsp_word.error && !rsp_word.is_empty, "found word flags an error or an empty table")

endmodule

bind indexed_table_with_search itws_chk u_chk (.*);
